// File: hdl/ssld_pkg.sv
// ----------------------------------------------------------------------------
// ssld_pkg: shared codes for the sorted signal list
// Command, result kind and commit status codes used by the list engine.
// ----------------------------------------------------------------------------
package ssld_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_COMMIT = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_REFUSE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_DUP      = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  localparam logic signed [7:0] STR_MIN = -8'sd128;
  localparam logic signed [7:0] STR_MAX = 8'sd127;

endpackage

// File: hdl/ssld_row_mem.sv
// ----------------------------------------------------------------------------
// ssld_row_mem: entry row memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssld_row_mem #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic                           re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);

  logic [W-1:0] mem [D];

  // write one row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read one row, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sorted_signal_list_dedup.sv
// Commit: a row read and a compare per stored entry scanned, then a row read and a row
//   write per entry shifted; the row memory port paces scan and shift.
// Read: fetches the row, then one word per cycle while the output is not stalled, one per name byte.
// Push: completes on acceptance, in idle. One item at a time; input stalls while an item is in work.
// Reset clears entry count and pending length; the row memory needs no clear.
// ----------------------------------------------------------------------------
// sorted_signal_list_dedup: bounded strength-sorted list with name dedup
// Sequencer around a row memory that holds name, length, strength and flag.
// ----------------------------------------------------------------------------
module sorted_signal_list_dedup #(
  parameter int CAPACITY   = 16,
  parameter int NAME_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [7:0]         in_name_byte,
  input  logic signed [15:0] in_strength,
  input  logic               in_secure,
  input  logic [3:0]         in_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [1:0]         out_status,
  output logic [3:0]         out_position,
  output logic [4:0]         out_entries,
  output logic [7:0]         out_byte,
  output logic signed [7:0]  out_strength,
  output logic               out_secure,
  output logic               out_last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = $clog2(NAME_BYTES + 1);
  localparam int KW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int NW = NAME_BYTES * 8;
  localparam int RW = NW + LW + 9;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SC_RD  = 10'b0000000010,
    S_SC_EV  = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_SH_RD  = 10'b0000010000,
    S_SH_WR  = 10'b0000100000,
    S_INS    = 10'b0001000000,
    S_REPORT = 10'b0010000000,
    S_RD_EM  = 10'b0100000000,
    S_SPARE  = 10'b1000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          i_r, i_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic                   match_r, match_nxt;
  logic [IW-1:0]          m_r, m_nxt;
  logic [IW-1:0]          j_r, j_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic signed [7:0]      str_r, str_nxt;
  logic                   sec_r, sec_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic [7:0]             pend_r [NAME_BYTES];
  logic [LW-1:0]          plen_r, plen_nxt;
  logic [NW-1:0]          pend_vec;

  logic                   mem_we, mem_re;
  logic [IW-1:0]          mem_waddr, mem_raddr;
  logic [RW-1:0]          mem_wdata, mem_rdata;

  logic [NW-1:0]          rd_name;
  logic [LW-1:0]          rd_len;
  logic signed [7:0]      rd_str;
  logic                   rd_sec;
  logic                   rd_match;

  logic                   in_acc, out_free, out_load;
  logic signed [7:0]      sat_str;
  logic [1:0]             ld_kind, ld_status;
  logic [3:0]             ld_pos;
  logic [7:0]             ld_byte;
  logic signed [7:0]      ld_str;
  logic                   ld_sec, ld_last;

  logic                   out_valid_r;
  logic [1:0]             out_kind_r, out_status_r;
  logic [3:0]             out_pos_r;
  logic [4:0]             out_ent_r;
  logic [7:0]             out_byte_r;
  logic signed [7:0]      out_str_r;
  logic                   out_sec_r, out_last_r;

  ssld_row_mem #(.W(RW), .D(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // unpack the row read last
  assign rd_sec  = mem_rdata[0];
  assign rd_str  = mem_rdata[8:1];
  assign rd_len  = mem_rdata[LW+8:9];
  assign rd_name = mem_rdata[RW-1:LW+9];

  // zero-padded pending name
  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      pend_vec[k*8 +: 8] = (LW'(k) < plen_r) ? pend_r[k] : 8'd0;
    end
  end

  assign rd_match = (rd_len == plen_r) && (rd_name == pend_vec);

  // saturate the raw strength
  always_comb begin
    if (in_strength < -16'sd128) begin
      sat_str = ssld_pkg::STR_MIN;
    end else if (in_strength > 16'sd127) begin
      sat_str = ssld_pkg::STR_MAX;
    end else begin
      sat_str = in_strength[7:0];
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    pos_nxt    = pos_r;
    match_nxt  = match_r;
    m_nxt      = m_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    str_nxt    = str_r;
    sec_nxt    = sec_r;
    status_nxt = status_r;
    kind_nxt   = kind_r;
    plen_nxt   = plen_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = j_r;
    mem_raddr  = IW'(i_r);
    mem_wdata  = mem_rdata;
    out_load   = 1'b0;
    ld_kind    = kind_r;
    ld_status  = 2'(ssld_pkg::ST_INSERTED);
    ld_pos     = 4'd0;
    ld_byte    = 8'd0;
    ld_str     = 8'sd0;
    ld_sec     = 1'b0;
    ld_last    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            2'(ssld_pkg::CMD_PUSH): begin
              if (in_name_byte != 8'd0 && plen_r < LW'(NAME_BYTES)) begin
                plen_nxt = plen_r + 1'b1;
              end
            end
            2'(ssld_pkg::CMD_COMMIT): begin
              str_nxt   = sat_str;
              sec_nxt   = in_secure;
              i_nxt     = '0;
              pos_nxt   = '0;
              match_nxt = 1'b0;
              kind_nxt  = 2'(ssld_pkg::KIND_COMMIT);
              if (plen_r == '0) begin
                status_nxt = 2'(ssld_pkg::ST_EMPTY);
                state_nxt  = S_REPORT;
              end else if (cnt_r == '0) begin
                state_nxt = S_DECIDE;
              end else begin
                state_nxt = S_SC_RD;
              end
            end
            2'(ssld_pkg::CMD_READ): begin
              if (7'(in_slot) >= 7'(cnt_r)) begin
                kind_nxt  = 2'(ssld_pkg::KIND_REFUSE);
                state_nxt = S_REPORT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = IW'(in_slot);
                k_nxt     = '0;
                state_nxt = S_RD_EM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SC_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_SC_EV;
      end
      S_SC_EV: begin
        // compare one stored entry, count the ones at least as strong
        if (rd_match && str_r <= rd_str) begin
          status_nxt = 2'(ssld_pkg::ST_DUP);
          state_nxt  = S_REPORT;
        end else begin
          if (rd_match) begin
            match_nxt = 1'b1;
            m_nxt     = IW'(i_r);
          end
          if (rd_str >= str_r) begin
            pos_nxt = pos_r + 1'b1;
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_r + 1'b1 == cnt_r) ? S_DECIDE : S_SC_RD;
        end
      end
      S_DECIDE: begin
        if (!match_r && pos_r >= CAP_C) begin
          status_nxt = 2'(ssld_pkg::ST_DROPPED);
          state_nxt  = S_REPORT;
        end else begin
          if (match_r) begin
            j_nxt = m_r;
          end else if (cnt_r < CAP_C) begin
            j_nxt   = IW'(cnt_r);
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            j_nxt = IW'(CAPACITY - 1);
          end
          state_nxt = (CW'(j_nxt) > pos_r) ? S_SH_RD : S_INS;
        end
      end
      S_SH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = j_r - 1'b1;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        // move the row down by one slot
        mem_we    = 1'b1;
        mem_waddr = j_r;
        j_nxt     = j_r - 1'b1;
        state_nxt = (CW'(j_r - 1'b1) > pos_r) ? S_SH_RD : S_INS;
      end
      S_INS: begin
        mem_we     = 1'b1;
        mem_waddr  = IW'(pos_r);
        mem_wdata  = {pend_vec, plen_r, str_r, sec_r};
        status_nxt = 2'(ssld_pkg::ST_INSERTED);
        state_nxt  = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_status = (kind_r == 2'(ssld_pkg::KIND_COMMIT)) ? status_r
                                                             : 2'(ssld_pkg::ST_INSERTED);
          ld_pos    = (kind_r == 2'(ssld_pkg::KIND_COMMIT) &&
                       status_r == 2'(ssld_pkg::ST_INSERTED)) ? 4'(pos_r) : 4'd0;
          if (kind_r == 2'(ssld_pkg::KIND_COMMIT)) begin
            plen_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_RD_EM: begin
        // stream one name byte per word
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = 2'(ssld_pkg::KIND_BYTE);
          ld_byte  = rd_name[k_r*8 +: 8];
          ld_str   = rd_str;
          ld_sec   = rd_sec;
          ld_last  = (LW'(k_r) + 1'b1 == rd_len);
          k_nxt    = k_r + 1'b1;
          if (ld_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      plen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      plen_r  <= plen_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    pos_r    <= pos_nxt;
    match_r  <= match_nxt;
    m_r      <= m_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    str_r    <= str_nxt;
    sec_r    <= sec_nxt;
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
  end

  // append a pending name byte
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && in_cmd == 2'(ssld_pkg::CMD_PUSH) &&
        in_name_byte != 8'd0 && plen_r < LW'(NAME_BYTES)) begin
      pend_r[KW'(plen_r)] <= in_name_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r   <= ld_kind;
      out_status_r <= ld_status;
      out_pos_r    <= ld_pos;
      out_ent_r    <= 5'(cnt_r);
      out_byte_r   <= ld_byte;
      out_str_r    <= ld_str;
      out_sec_r    <= ld_sec;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_entries  = out_ent_r;
  assign out_byte     = out_byte_r;
  assign out_strength = out_str_r;
  assign out_secure   = out_sec_r;
  assign out_last     = out_last_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C) else $error("entry count beyond capacity");

  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LW'(NAME_BYTES)) else $error("pending length beyond name size");

  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re)) else $error("row read and write collide");

  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != 2'(ssld_pkg::KIND_BYTE) |-> out_last_r)
    else $error("single-word result without last");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the sorted signal list with name dedup
// Drives push, commit and read words, predicts each result word from a local
// model of the sorted list, and checks the results in order under random idling.
// ----------------------------------------------------------------------------
module tb;

  localparam int CAP   = 16;
  localparam int NB    = 32;
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [3:0]        position;
    logic [4:0]        entries;
    logic [7:0]        bval;
    logic signed [7:0] str;
    logic              sec;
    logic              last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = ssld_pkg::CMD_PUSH;
  logic [7:0] in_name_byte = '0;
  logic signed [15:0] in_strength = '0;
  logic in_secure = 1'b0;
  logic [3:0] in_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [1:0] out_status;
  logic [3:0] out_position;
  logic [4:0] out_entries;
  logic [7:0] out_byte;
  logic signed [7:0] out_strength;
  logic out_secure;
  logic out_last;

  sorted_signal_list_dedup DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_name_byte(in_name_byte), .in_strength(in_strength), .in_secure(in_secure),
    .in_slot(in_slot), .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_status(out_status), .out_position(out_position),
    .out_entries(out_entries), .out_byte(out_byte), .out_strength(out_strength),
    .out_secure(out_secure), .out_last(out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // list model
  logic [7:0]        lst_name [CAP][NB];
  int                lst_len  [CAP];
  logic signed [7:0] lst_str  [CAP];
  logic              lst_sec  [CAP];
  int                lst_count;
  logic [7:0]        pend_name [NB];
  int                pend_len;

  result_t expected_q[$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  int idle_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic logic name_matches(int e);
    if (lst_len[e] != pend_len) return 1'b0;
    for (int k = 0; k < pend_len; k++)
      if (lst_name[e][k] != pend_name[k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void move_entry(int dst, int src);
    lst_name[dst] = lst_name[src];
    lst_len[dst]  = lst_len[src];
    lst_str[dst]  = lst_str[src];
    lst_sec[dst]  = lst_sec[src];
  endfunction

  // try the pending name into the list; returns status, sets slot
  function automatic ssld_pkg::status_t insert_report(logic signed [7:0] s, logic sc,
                                                      output int where);
    int p;
    where = 0;
    if (pend_len == 0) return ssld_pkg::ST_EMPTY;
    for (int i = 0; i < lst_count; i++) begin
      if (name_matches(i)) begin
        if (s <= lst_str[i]) return ssld_pkg::ST_DUP;
        for (int j = i; j + 1 < lst_count; j++) move_entry(j, j + 1);
        lst_count--;
        break;
      end
    end
    p = 0;
    while (p < lst_count && lst_str[p] >= s) p++;
    if (p >= CAP) return ssld_pkg::ST_DROPPED;
    if (lst_count < CAP) lst_count++;
    for (int j = lst_count - 1; j > p; j--) move_entry(j, j - 1);
    for (int k = 0; k < NB; k++) lst_name[p][k] = (k < pend_len) ? pend_name[k] : 8'd0;
    lst_len[p] = pend_len;
    lst_str[p] = s;
    lst_sec[p] = sc;
    where = p;
    return ssld_pkg::ST_INSERTED;
  endfunction

  // predict the result words of one accepted word
  function automatic void predict_word(logic [1:0] c, logic [7:0] b,
                                       logic signed [15:0] raw, logic sc,
                                       logic [3:0] sl);
    result_t r;
    logic signed [7:0] s;
    int where;
    ssld_pkg::status_t st;
    r = '0;
    case (c)
      ssld_pkg::CMD_PUSH: begin
        if (b != 0 && pend_len < NB) begin
          pend_name[pend_len] = b;
          pend_len++;
        end
      end
      ssld_pkg::CMD_COMMIT: begin
        if (raw < -128) s = ssld_pkg::STR_MIN;
        else if (raw > 127) s = ssld_pkg::STR_MAX;
        else s = raw[7:0];
        st = insert_report(s, sc, where);
        pend_len = 0;
        r.kind = ssld_pkg::KIND_COMMIT;
        r.status = st;
        r.position = where[3:0];
        r.entries = lst_count[4:0];
        r.last = 1'b1;
        expected_q.push_back(r);
      end
      ssld_pkg::CMD_READ: begin
        if (sl >= lst_count) begin
          r.kind = ssld_pkg::KIND_REFUSE;
          r.entries = lst_count[4:0];
          r.last = 1'b1;
          expected_q.push_back(r);
        end else begin
          for (int k = 0; k < lst_len[sl]; k++) begin
            r = '0;
            r.kind = ssld_pkg::KIND_BYTE;
            r.entries = lst_count[4:0];
            r.bval = lst_name[sl][k];
            r.str = lst_str[sl];
            r.sec = lst_sec[sl];
            r.last = (k + 1 == lst_len[sl]);
            expected_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // send one word and wait for its acceptance
  task automatic send_word(logic [1:0] c, logic [7:0] b, logic signed [15:0] raw,
                           logic sc, logic [3:0] sl);
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk);
    in_valid = 1'b1;
    in_cmd = c;
    in_name_byte = b;
    in_strength = raw;
    in_secure = sc;
    in_slot = sl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(c, b, raw, sc, sl);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic push_name(int n, int base);
    for (int k = 0; k < n; k++)
      send_word(ssld_pkg::CMD_PUSH,
                (base < 0) ? 8'($urandom_range(255, 1)) : 8'(base + k),
                16'($urandom), 1'($urandom), 4'($urandom));
  endtask

  task automatic commit_report(logic signed [15:0] raw, logic sc);
    send_word(ssld_pkg::CMD_COMMIT, 8'($urandom), raw, sc, 4'($urandom));
  endtask

  task automatic read_slot(logic [3:0] sl);
    send_word(ssld_pkg::CMD_READ, 8'($urandom), 16'($urandom), 1'($urandom), sl);
  endtask

  // drive receiver stall; check each accepted result word
  always @(negedge clk)
    out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result word kind=%0d", out_kind);
        errors++;
      end else begin
        result_t e;
        e = expected_q.pop_front();
        got++;
        if (out_kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_kind); errors++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_position !== e.position) begin
          $error("position exp %0d got %0d", e.position, out_position); errors++;
        end
        if (out_entries !== e.entries) begin
          $error("entries exp %0d got %0d", e.entries, out_entries); errors++;
        end
        if (out_byte !== e.bval) begin
          $error("out_byte exp %0d got %0d", e.bval, out_byte); errors++;
        end
        if (out_strength !== e.str) begin
          $error("out_strength exp %0d got %0d", e.str, out_strength); errors++;
        end
        if (out_secure !== e.sec) begin
          $error("out_secure exp %0d got %0d", e.sec, out_secure); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // directed: empty, overlong names, dedup, saturation, reads, unused command
  task automatic test_directed();
    commit_report(16'sd5, 1'b0);
    read_slot(4'd0);
    push_name(40, 1);
    commit_report(16'sh7FFF, 1'b1);
    send_word(ssld_pkg::CMD_PUSH, 8'd0, 16'sd0, 1'b0, 4'd0);
    push_name(3, 65);
    commit_report(-16'sd32768, 1'b0);
    push_name(3, 65);
    commit_report(-16'sd200, 1'b1);
    push_name(3, 65);
    commit_report(16'sd10, 1'b1);
    send_word(ssld_pkg::CMD_NONE, 8'hFF, 16'shFFFF, 1'b1, 4'hF);
    read_slot(4'd0);
    read_slot(4'd1);
    read_slot(4'd15);
  endtask

  // fill past capacity with a small name pool so dedup, drop and evict all occur
  task automatic test_random(int n);
    int start;
    logic signed [15:0] raw;
    start = sent;
    while (sent - start < n) begin
      case ($urandom_range(9))
        0: begin
          send_word(2'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                    4'($urandom));
        end
        1, 2, 3: begin
          read_slot(4'($urandom));
        end
        default: begin
          if ($urandom_range(3) == 0) push_name($urandom_range(34, 1), -1);
          else push_name($urandom_range(3, 1), 16 * $urandom_range(11) + 1);
          case ($urandom_range(3))
            0: raw = 16'($urandom);
            1: raw = 16'($signed($urandom_range(300)) - 150);
            default: raw = 16'($signed($urandom_range(20)) - 10);
          endcase
          commit_report(raw, 1'($urandom));
        end
      endcase
    end
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    lst_count = 0;
    pend_len = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    send_idle = 35;
    recv_idle = 52;
    test_directed();
    test_random(130);
    drain();
    send_idle = 52;
    recv_idle = 35;
    test_random(130);
    drain();
    send_idle = 0;
    recv_idle = 0;
    test_random(140);
    drain();
    $display("covered %0d input words and %0d result words under three idle mixes",
             sent, got);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
